### design/ctc_pkg.sv
// package for the checkpoint table checker: request and result types, codes and defaults
`default_nettype none
package ctc_pkg;

  localparam int unsigned EntriesDefault = 64;
  localparam int unsigned HeightW = 64;
  localparam int unsigned WordW = 64;
  localparam int unsigned HashW = 4 * WordW;
  localparam int unsigned WindowW = 16;
  localparam logic [WindowW-1:0] WindowReset = 16'd10;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_ZONE  = 2'd2,
    REQ_ALT   = 2'd3
  } req_kind_e;

  localparam logic [1:0] AddOk   = 2'd0;
  localparam logic [1:0] AddDup  = 2'd1;
  localparam logic [1:0] AddFull = 2'd2;

  typedef struct packed {
    req_kind_e          req_type;
    logic [HeightW-1:0] height;
    logic [HeightW-1:0] chain_height;
    logic [WordW-1:0]   hash_word0;
    logic [WordW-1:0]   hash_word1;
    logic [WordW-1:0]   hash_word2;
    logic [WordW-1:0]   hash_word3;
  } req_t;

  typedef struct packed {
    logic [1:0] add_status;
    logic       is_checkpoint;
    logic       verdict;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_HRD  = 5'b00100,
    ST_HCMP = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage
`default_nettype wire

### design/ctc_table.sv
// checkpoint storage: height memory and hash row memory, one write and one registered read
`default_nettype none
module ctc_table #(
  parameter int unsigned ENTRIES = ctc_pkg::EntriesDefault,
  parameter int unsigned AW = 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [AW-1:0]                wr_addr_i,
  input  wire logic [ctc_pkg::HeightW-1:0]  wr_height_i,
  input  wire logic [ctc_pkg::HashW-1:0]    wr_hash_i,
  input  wire logic [AW-1:0]                rd_addr_i,
  output logic      [ctc_pkg::HeightW-1:0]  rd_height_o,
  output logic      [ctc_pkg::HashW-1:0]    rd_hash_o
);
  import ctc_pkg::*;

  logic [HeightW-1:0] height_mem [ENTRIES];
  logic [HashW-1:0]   hash_mem   [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      height_mem[wr_addr_i] <= wr_height_i;
      hash_mem[wr_addr_i]   <= wr_hash_i;
    end
    rd_height_o <= height_mem[rd_addr_i];
    rd_hash_o   <= hash_mem[rd_addr_i];
  end

endmodule
`default_nettype wire

### design/ctc_engine.sv
// request sequencer: scans the table with one shared compare stage and builds each result
`default_nettype none
module ctc_engine #(
  parameter int unsigned ENTRIES = ctc_pkg::EntriesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire ctc_pkg::req_t                req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ctc_pkg::rsp_t                     rsp_o,
  input  wire logic [ctc_pkg::WindowW-1:0]  window_i
);
  import ctc_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_e state_q, state_d;
  req_t   req_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          found_q, found_d;
  logic [AW-1:0] match_q, match_d;
  logic [HeightW-1:0] top_q, top_d;
  logic          bfound_q, bfound_d;
  logic [HeightW-1:0] best_q, best_d;
  logic          hash_eq_q, hash_eq_d;
  logic          out_valid_q;
  rsp_t          rsp_q;

  logic               accept;
  logic               leave;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [HeightW-1:0] rd_height;
  logic [HashW-1:0]   rd_hash;
  logic [HashW-1:0]   req_hash;
  logic [HeightW-1:0] limit;
  logic               in_zone;
  logic               full;
  rsp_t               rsp_d;

  assign req_hash = {req_q.hash_word3, req_q.hash_word2, req_q.hash_word1, req_q.hash_word0};
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign leave    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign full     = (count_q >= CW'(ENTRIES));
  assign wr_en    = leave && (req_q.req_type == REQ_ADD) && !found_q && !full;
  assign rd_addr  = (state_q == ST_HRD) ? match_q : idx_q[AW-1:0];
  assign limit    = req_q.chain_height - {{(HeightW-WindowW){1'b0}}, window_i};
  assign in_zone  = (count_q != '0) && (req_q.height <= top_q);

  ctc_table #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_table (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (count_q[AW-1:0]),
    .wr_height_i (req_q.height),
    .wr_hash_i   (req_hash),
    .rd_addr_i   (rd_addr),
    .rd_height_o (rd_height),
    .rd_hash_o   (rd_hash)
  );

  always_comb begin
    rsp_d = '0;
    unique case (req_q.req_type)
      REQ_ADD: begin
        if (found_q) begin
          rsp_d.add_status = AddDup;
        end else if (full) begin
          rsp_d.add_status = AddFull;
        end else begin
          rsp_d.add_status = AddOk;
        end
      end
      REQ_CHECK: begin
        rsp_d.is_checkpoint = found_q;
        rsp_d.verdict       = !found_q || hash_eq_q;
      end
      REQ_ZONE: begin
        rsp_d.verdict = in_zone;
      end
      REQ_ALT: begin
        if (req_q.height == '0) begin
          rsp_d.verdict = 1'b0;
        end else if ((req_q.height < limit) && !in_zone) begin
          rsp_d.verdict = 1'b0;
        end else begin
          rsp_d.verdict = !bfound_q || (best_q < req_q.height);
        end
      end
      default: rsp_d = '0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    rd_idx_d  = rd_idx_q;
    found_d   = found_q;
    match_d   = match_q;
    top_d     = top_q;
    bfound_d  = bfound_q;
    best_d    = best_q;
    hash_eq_d = hash_eq_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_SCAN;
          idx_d    = '0;
          found_d  = 1'b0;
          top_d    = '0;
          bfound_d = 1'b0;
          best_d   = '0;
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is compared
        if (idx_q < count_q) begin
          idx_d    = idx_q + 1'b1;
          pend_d   = 1'b1;
          rd_idx_d = idx_q[AW-1:0];
        end else if (!pend_q) begin
          if ((req_q.req_type == REQ_CHECK) && found_q) begin
            state_d = ST_HRD;
          end else begin
            state_d = ST_DONE;
          end
        end
        if (pend_q) begin
          if (!found_q && (rd_height == req_q.height)) begin
            found_d = 1'b1;
            match_d = rd_idx_q;
          end
          if (rd_height > top_q) begin
            top_d = rd_height;
          end
          if ((rd_height <= req_q.chain_height) && (!bfound_q || (rd_height > best_q))) begin
            bfound_d = 1'b1;
            best_d   = rd_height;
          end
        end
      end
      ST_HRD: begin
        state_d = ST_HCMP;
      end
      ST_HCMP: begin
        hash_eq_d = (rd_hash == req_hash);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (leave) begin
          state_d = ST_IDLE;
          if (wr_en) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      bfound_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      bfound_q <= bfound_d;
      if (leave) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (leave) begin
      rsp_q <= rsp_d;
    end
    rd_idx_q  <= rd_idx_d;
    match_q   <= match_d;
    top_q     <= top_d;
    best_q    <= best_d;
    hash_eq_q <= hash_eq_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  a_write_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q == $past(count_q) + 1'b1))
    else $error("table write without count increment");

  a_hash_after_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HRD) |-> (found_q && (req_q.req_type == REQ_CHECK)))
    else $error("hash read without a height match");

  a_result_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    leave |=> (state_q == ST_IDLE))
    else $error("result loaded without return to idle");

endmodule
`default_nettype wire

### design/checkpoint_table_checker_unit.sv
// Checkpoint table checker, top level with the APB register port.
// Requests arrive on in_valid_i/in_stall_o with in_req_i; one result per request leaves on
// out_valid_o/out_stall_i with out_rsp_o. A transfer happens when valid is high and stall low.
// Each request scans every stored entry once through the height memory, one entry per
// cycle with a registered read, before its result is built; a check that hits a stored
// height then reads its hash row and compares it. The block takes one request at a time
// and holds in_stall_o high until the result is loaded into the output register; a new
// request may be taken while that result still waits. When the receiver stalls, the
// result holds and the next result waits in its final step until the register frees.
// Reset empties the table (entry count zero) and sets unlock_window to 10; no clearing
// pass is needed. unlock_window lies at byte address 0; pready is always high.
`default_nettype none
module checkpoint_table_checker_unit #(
  parameter int unsigned ENTRIES = ctc_pkg::EntriesDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ctc_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ctc_pkg::rsp_t      out_rsp_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ctc_pkg::*;

  localparam logic RegUnlockWindow = 1'b0;

  logic [WindowW-1:0] window_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegUnlockWindow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_wr) begin
      window_q <= pwdata[WindowW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegUnlockWindow) ? {{(32-WindowW){1'b0}}, window_q} : 32'd0;

  ctc_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (out_rsp_o),
    .window_i    (window_q)
  );

endmodule
`default_nettype wire
